FILE: src/vcb_pkg.sv
`timescale 1ns / 1ps
// Package: shared constants, types and register indexes for the crossfade blender.
package vcb_pkg;

    localparam int CountWidth = 16;
    localparam int CfgDataWidth = 16;
    localparam int CfgIndexWidth = 3;
    localparam int SampleWidth = 8;
    localparam int SumWidth = 2 * SampleWidth;
    localparam int NumWidth = SampleWidth + CountWidth;
    localparam int QuoSteps = SampleWidth;
    localparam int QDepth = 4;
    localparam int QPtrWidth = $clog2(QDepth);
    localparam logic [SampleWidth-1:0] FullScale = 8'd255;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_START_OPACITY  = 3'd0,
        REG_END_OPACITY    = 3'd1,
        REG_DURATION       = 3'd2,
        REG_SKIP           = 3'd3,
        REG_PROCESS        = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [SampleWidth-1:0] sample_first;
        logic [SampleWidth-1:0] sample_second;
        logic                   frame_last_sample;
    } in_word_t;

    typedef struct packed {
        logic [SampleWidth-1:0] blended_sample;
        logic                   frame_end;
        logic                   transition_done;
    } out_word_t;

    typedef struct packed {
        logic [SampleWidth-1:0] opacity;
        logic [SampleWidth-1:0] sample_first;
        logic [SampleWidth-1:0] sample_second;
        logic                   frame_end;
        logic                   transition_done;
    } q_word_t;

    typedef struct packed {
        logic                  start;
        logic [CountWidth-1:0] frame;
    } ramp_req_t;

    typedef struct packed {
        logic [SampleWidth-1:0] start_opacity;
        logic [SampleWidth-1:0] end_opacity;
        logic [CountWidth-1:0]  duration;
    } ramp_cfg_t;

endpackage

FILE: src/vcb_ramp.sv
`timescale 1ns / 1ps
// Per-frame opacity ramp: multiply stage then an 8-step restoring divider.
module vcb_ramp
    import vcb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ramp_req_t              req,
    input  ramp_cfg_t              cfg,
    output logic                   busy,
    output logic [SampleWidth-1:0] opacity
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_DIV  = 3'b100
    } ramp_state_t;

    ramp_state_t state_reg, state_next;
    logic [CountWidth-1:0]  frame_reg;
    logic [NumWidth-1:0]    rem_reg, rem_next;
    logic [NumWidth-1:0]    dvs_reg, dvs_next;
    logic [SampleWidth-1:0] quo_reg, quo_next;
    logic [$clog2(QuoSteps)-1:0] cnt_reg, cnt_next;
    logic [SampleWidth-1:0] opa_reg, opa_next;

    logic [CountWidth-1:0] span;
    logic [CountWidth-1:0] diff;
    logic [NumWidth-1:0]   prod_a;
    logic [NumWidth-1:0]   prod_b;
    logic [NumWidth-1:0]   num;
    logic                  fits;

    assign span   = cfg.duration - CountWidth'(1);
    assign diff   = span - frame_reg;
    assign prod_a = NumWidth'(cfg.start_opacity) * NumWidth'(diff);
    assign prod_b = NumWidth'(cfg.end_opacity) * NumWidth'(frame_reg);
    assign num    = prod_a + prod_b;
    assign fits   = rem_reg >= dvs_reg;

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        opa_next   = opa_reg;
        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_MUL: begin
                if (cfg.duration <= CountWidth'(1)) begin
                    opa_next   = cfg.start_opacity;
                    state_next = ST_IDLE;
                end else if (frame_reg >= cfg.duration) begin
                    opa_next   = cfg.end_opacity;
                    state_next = ST_IDLE;
                end else begin
                    rem_next   = num;
                    dvs_next   = {1'b0, span, {(QuoSteps-1){1'b0}}};
                    quo_next   = '0;
                    cnt_next   = '1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                quo_next = {quo_reg[SampleWidth-2:0], fits};
                if (fits) begin
                    rem_next = rem_reg - dvs_reg;
                end
                dvs_next = dvs_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    opa_next   = quo_next;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (req.start) begin
            state_next = ST_MUL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        if (req.start) begin
            frame_reg <= req.frame;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        opa_reg <= opa_next;
    end

    assign busy    = state_reg != ST_IDLE;
    assign opacity = opa_reg;

endmodule

FILE: src/vcb_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, frame window tracking, item classification.
module vcb_front
    import vcb_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_word_t                 s_data,
    output logic                     q_push,
    output q_word_t                  q_data,
    input  logic                     q_full
);

    logic [SampleWidth-1:0] start_reg, end_reg;
    logic [CountWidth-1:0]  dur_reg, skip_reg, proc_reg;
    logic                   pend_reg;
    logic                   win_ok_reg;
    logic [CountWidth:0]    win_end_reg;
    logic [CountWidth:0]    frame_reg;
    logic                   fin_reg;

    logic [CountWidth-1:0]  count;
    logic [CountWidth:0]    win_end;
    logic                   win_ok;
    logic [CountWidth:0]    frame_inc;
    logic                   emit;
    logic                   accept;
    logic                   launch;
    logic                   done;
    logic                   cfg_hit;
    ramp_req_t              req;
    ramp_cfg_t              rcfg;
    logic                   ramp_busy;
    logic [SampleWidth-1:0] opacity;

    assign count   = (proc_reg != '0) ? proc_reg : dur_reg - skip_reg;
    assign win_end = {1'b0, skip_reg} + {1'b0, count};
    assign win_ok  = (dur_reg != '0) && (skip_reg <= dur_reg) && (count != '0)
                     && (win_end <= {1'b0, dur_reg});

    assign emit      = win_ok_reg && !fin_reg;
    assign s_ready   = !pend_reg && !ramp_busy && (!emit || !q_full);
    assign accept    = s_valid && s_ready;
    assign launch    = pend_reg && !cfg_we;
    assign frame_inc = frame_reg + 1'b1;
    assign done      = s_data.frame_last_sample && (frame_inc >= win_end_reg);
    assign cfg_hit   = cfg_we && (cfg_index <= REG_PROCESS);

    assign req.start = launch || (accept && emit && s_data.frame_last_sample && !done);
    assign req.frame = launch ? skip_reg : frame_inc[CountWidth-1:0];
    assign rcfg.start_opacity = start_reg;
    assign rcfg.end_opacity   = end_reg;
    assign rcfg.duration      = dur_reg;

    vcb_ramp u_ramp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .cfg     (rcfg),
        .busy    (ramp_busy),
        .opacity (opacity)
    );

    assign q_push                 = accept && emit;
    assign q_data.opacity         = opacity;
    assign q_data.sample_first    = s_data.sample_first;
    assign q_data.sample_second   = s_data.sample_second;
    assign q_data.frame_end       = s_data.frame_last_sample;
    assign q_data.transition_done = done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg   <= '0;
            end_reg     <= FullScale;
            dur_reg     <= CountWidth'(1);
            skip_reg    <= '0;
            proc_reg    <= '0;
            pend_reg    <= 1'b1;
            win_ok_reg  <= 1'b0;
            win_end_reg <= '0;
            frame_reg   <= '0;
            fin_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_START_OPACITY: start_reg <= cfg_wdata[SampleWidth-1:0];
                    REG_END_OPACITY:   end_reg   <= cfg_wdata[SampleWidth-1:0];
                    REG_DURATION:      dur_reg   <= cfg_wdata[CountWidth-1:0];
                    REG_SKIP:          skip_reg  <= cfg_wdata[CountWidth-1:0];
                    REG_PROCESS:       proc_reg  <= cfg_wdata[CountWidth-1:0];
                    default: begin
                    end
                endcase
            end
            if (cfg_hit) begin
                pend_reg <= 1'b1;
            end else if (launch) begin
                pend_reg <= 1'b0;
            end
            if (launch) begin
                win_ok_reg  <= win_ok;
                win_end_reg <= win_end;
                frame_reg   <= {1'b0, skip_reg};
                fin_reg     <= 1'b0;
            end else if (accept && emit && s_data.frame_last_sample) begin
                frame_reg <= frame_inc;
                if (done) begin
                    fin_reg <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: src/vcb_fifo.sv
`timescale 1ns / 1ps
// Short word queue decoupling the front end from the blend pipeline.
module vcb_fifo
    import vcb_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  q_word_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    not_empty,
    output q_word_t pop_data
);

    q_word_t              mem_reg [QDepth];
    logic [QPtrWidth-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPtrWidth:0]   cnt_reg;
    logic                 do_push, do_pop;

    assign full      = cnt_reg == (QPtrWidth+1)'(QDepth);
    assign not_empty = cnt_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/vcb_back.sv
`timescale 1ns / 1ps
// Back end: weighted mix, divide by full scale, output register.
module vcb_back
    import vcb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    input  q_word_t   q_data,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic                   mix_v_reg;
    logic [SumWidth-1:0]    sum_reg;
    logic                   mix_end_reg, mix_done_reg;
    logic                   out_v_reg;
    out_word_t              out_reg;

    logic [SumWidth-1:0]    prod_first, prod_second;
    logic [SumWidth:0]      scaled;
    logic                   out_adv, mix_adv;

    assign prod_first  = SumWidth'(FullScale - q_data.opacity) * SumWidth'(q_data.sample_first);
    assign prod_second = SumWidth'(q_data.opacity) * SumWidth'(q_data.sample_second);
    // floor(x / 255) for x <= 255 * 255
    assign scaled = {1'b0, sum_reg} + (SumWidth+1)'(sum_reg >> SampleWidth) + 1'b1;

    assign out_adv = !out_v_reg || m_ready;
    assign mix_adv = !mix_v_reg || out_adv;
    assign q_pop   = q_valid && mix_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mix_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (mix_adv) begin
                mix_v_reg <= q_valid;
            end
            if (out_adv) begin
                out_v_reg <= mix_v_reg;
            end
        end
        if (q_pop) begin
            sum_reg      <= prod_first + prod_second;
            mix_end_reg  <= q_data.frame_end;
            mix_done_reg <= q_data.transition_done;
        end
        if (out_adv && mix_v_reg) begin
            out_reg.blended_sample  <= scaled[SumWidth-1:SampleWidth];
            out_reg.frame_end       <= mix_end_reg;
            out_reg.transition_done <= mix_done_reg;
        end
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

endmodule

FILE: src/video_crossfade_blender_top.sv
`timescale 1ns / 1ps
// Top level of the video crossfade blender.
//
// Input words (s_valid/s_ready/s_data) carry one sample of each stream and a
// last-sample-of-frame flag. Output words (m_valid/m_ready/m_data) carry the
// blended sample, a frame end flag and a transition done flag on the last
// sample of the final output frame. When the frame window is invalid every
// word is accepted and dropped; after the final frame every word is dropped
// until a register write or reset.
// Registers are written through cfg_we/cfg_index/cfg_wdata while idle; any
// write to a defined index restarts the transition.
// Throughput: one word per cycle within a frame while the queue has room.
// After each frame end the input stalls while the opacity of the next frame
// is computed (a multiply step plus an eight-step divider); after reset and
// after a register write it also stalls for the launch and that computation.
// Words pass the queue, mix register and output register before m_data.
// When the receiver stalls, a four-word queue and the blend pipeline fill,
// then s_ready drops. Reset clears the queue and restores default registers.
module video_crossfade_blender_top
    import vcb_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_word_t                 s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_word_t                m_data
);

    logic    q_push, q_full, q_pop, q_valid;
    q_word_t q_in, q_out;

    vcb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_push    (q_push),
        .q_data    (q_in),
        .q_full    (q_full)
    );

    vcb_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    vcb_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: src/vcb_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the crossfade blender and its bind.
module vcb_checker
    import vcb_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     cfg_we,
    input logic [CfgIndexWidth-1:0] cfg_index,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input out_word_t                m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

    a_done_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.transition_done || m_data.frame_end))
        else $error("transition done without frame end");

    a_cfg_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we && (cfg_index <= REG_PROCESS) |=> !s_ready)
        else $error("input ready right after register write");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind video_crossfade_blender_top vcb_checker u_vcb_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);

FILE: tb/video_crossfade_blender_top_test.sv
`timescale 1ns / 1ps
// Testbench for the crossfade blender: random and directed words, a scoreboard and a watchdog.
module video_crossfade_blender_top_test;
    import vcb_pkg::*;

    localparam int ResetCycles = 9;
    localparam int IdleGap = 24;
    localparam int HoldCycles = 240;
    localparam int HoldPhase = 2;
    localparam int HoldFrameLen = 40;
    localparam int RandomWords = 1100;
    localparam int NumRegs = 5;
    localparam int MaxFramesPerPhase = 6;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_LIGHT
    } stall_mode_t;

    class blend_scoreboard;
        logic [SampleWidth-1:0] op_start;
        logic [SampleWidth-1:0] op_end;
        logic [SampleWidth-1:0] opacity;
        logic [CountWidth-1:0]  dur;
        logic [CountWidth-1:0]  skp;
        logic [CountWidth-1:0]  prc;
        logic [CountWidth-1:0]  frame_idx;
        int unsigned            window_end;
        bit                     window_ok;
        bit                     finished;
        out_word_t              expected_q[$];
        int                     errors;
        int                     checked;
        int                     issued;
        int                     frame_ends;
        int                     transitions;

        function new();
            errors = 0;
            checked = 0;
            issued = 0;
            frame_ends = 0;
            transitions = 0;
            op_start = '0;
            op_end = 8'd255;
            dur = 16'd1;
            skp = '0;
            prc = '0;
            restart();
        endfunction

        function logic [SampleWidth-1:0] ramp_opacity(int unsigned f);
            int unsigned span;
            int unsigned q;
            if (dur <= 1) return op_start;
            if (f >= dur) return op_end;
            span = dur - 1;
            q = (op_start * (span - f) + op_end * f) / span;
            return q[SampleWidth-1:0];
        endfunction

        function void restart();
            int unsigned cnt;
            window_ok = 1'b0;
            window_end = 0;
            if (dur != 0 && skp <= dur) begin
                cnt = (prc != 0) ? int'(prc) : int'(dur) - int'(skp);
                window_end = skp + cnt;
                window_ok = (cnt != 0) && (window_end <= dur);
            end
            frame_idx = skp;
            opacity = ramp_opacity(32'(skp));
            finished = 1'b0;
        endfunction

        function void write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] val);
            case (idx)
                REG_START_OPACITY: op_start = val[SampleWidth-1:0];
                REG_END_OPACITY:   op_end = val[SampleWidth-1:0];
                REG_DURATION:      dur = val[CountWidth-1:0];
                REG_SKIP:          skp = val[CountWidth-1:0];
                REG_PROCESS:       prc = val[CountWidth-1:0];
                default:           return;
            endcase
            restart();
        endfunction

        function bit note_input(in_word_t w);
            out_word_t   r;
            int unsigned a;
            int unsigned mix;
            if (!window_ok || finished) return 1'b0;
            a = 32'(opacity);
            mix = ((FullScale - a) * w.sample_first + a * w.sample_second) / FullScale;
            r.blended_sample = mix[SampleWidth-1:0];
            r.frame_end = w.frame_last_sample;
            r.transition_done = 1'b0;
            if (w.frame_last_sample) begin
                frame_idx = frame_idx + 1'b1;
                if (frame_idx >= window_end) begin
                    finished = 1'b1;
                    r.transition_done = 1'b1;
                end else begin
                    opacity = ramp_opacity(32'(frame_idx));
                end
            end
            expected_q.push_back(r);
            issued++;
            return 1'b1;
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (expected_q.size() == 0) begin
                $error("output word with nothing expected: %p", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.blended_sample !== want.blended_sample) begin
                $error("blended_sample expected %0d got %0d",
                       want.blended_sample, got.blended_sample);
                errors++;
            end
            if (got.frame_end !== want.frame_end) begin
                $error("frame_end expected %0d got %0d", want.frame_end, got.frame_end);
                errors++;
            end
            if (got.transition_done !== want.transition_done) begin
                $error("transition_done expected %0d got %0d",
                       want.transition_done, got.transition_done);
                errors++;
            end
            if (got.frame_end === 1'b1) frame_ends++;
            if (got.transition_done === 1'b1) transitions++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void finish_check();
            if (expected_q.size() != 0) begin
                $error("%0d expected words never arrived", expected_q.size());
                errors++;
            end
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [CfgDataWidth-1:0]  cfg_wdata = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    in_word_t                 s_data = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    out_word_t                m_data;

    blend_scoreboard sb = new();
    bit hold_req = 1'b0;
    int burst_left = 0;
    int words_sent = 0;
    int settings_run = 0;

    video_crossfade_blender_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // receiver stall pattern, plus one long hold-off on request
    initial begin
        int          cyc;
        stall_mode_t mode;
        cyc = 0;
        mode = STALL_NONE;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HoldCycles - 1) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                if (cyc % 48 == 0) mode = stall_mode_t'($urandom_range(0, 3));
                cyc++;
                case (mode)
                    STALL_NONE:  m_ready <= 1'b1;
                    STALL_HALF:  m_ready <= 1'($urandom_range(0, 1));
                    STALL_HEAVY: m_ready <= ($urandom_range(0, 3) == 0);
                    default:     m_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    initial begin
        #(64'd6_000_000);
        $display("FAIL video_crossfade_blender_top");
        $finish;
    end

    function automatic logic [SampleWidth-1:0] rand_sample();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_word(input in_word_t w);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
                burst_left = 120;
                gap = 0;
            end else begin
                burst_left = $urandom_range(1, 20);
                gap = $urandom_range(0, 8);
            end
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        void'(sb.note_input(w));
        words_sent++;
    endtask

    task automatic send_sample(input logic [7:0] s0, input logic [7:0] s1, input logic last);
        in_word_t w;
        w.sample_first = s0;
        w.sample_second = s1;
        w.frame_last_sample = last;
        send_word(w);
    endtask

    task automatic send_frame(input int len);
        logic last;
        for (int i = 0; i < len; i++) begin
            last = (i == len - 1) || ($urandom_range(0, 19) == 0);
            send_sample(rand_sample(), rand_sample(), last);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (IdleGap) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [7:0] op_a, input logic [7:0] op_b,
                                input logic [15:0] dur, input logic [15:0] skp,
                                input logic [15:0] prc, input bit with_unused);
        logic [CfgIndexWidth-1:0] idx[NumRegs + 1];
        logic [CfgDataWidth-1:0]  val[NumRegs + 1];
        int                       n;
        n = 0;
        if (with_unused) begin
            idx[n] = CfgIndexWidth'($urandom_range(NumRegs, 7));
            val[n] = CfgDataWidth'($urandom);
            n++;
        end
        idx[n] = REG_START_OPACITY;
        val[n] = {8'($urandom), op_a};
        n++;
        idx[n] = REG_END_OPACITY;
        val[n] = {8'($urandom), op_b};
        n++;
        idx[n] = REG_DURATION;
        val[n] = dur;
        n++;
        idx[n] = REG_SKIP;
        val[n] = skp;
        n++;
        idx[n] = REG_PROCESS;
        val[n] = prc;
        n++;
        wait_idle();
        for (int i = 0; i < n; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    initial begin
        logic [7:0]  op_a;
        logic [7:0]  op_b;
        logic [15:0] d;
        logic [15:0] s;
        logic [15:0] p;
        int          kind;
        int          nfr;
        int          lim;
        int          base;
        int          phase;
        int          flen;

        repeat (ResetCycles) @(posedge aclk);
        aresetn <= 1'b1;
        wait_idle();

        // defaults after reset: one frame at opacity zero, then dropped words
        send_sample(8'd255, 8'd0, 1'b0);
        send_sample(8'd0, 8'd255, 1'b0);
        send_sample(8'd255, 8'd255, 1'b1);
        send_sample(8'd0, 8'd0, 1'b1);

        // falling ramp over three one-word frames
        program_regs(8'd255, 8'd0, 16'd3, 16'd0, 16'd0, 1'b0);
        send_sample(8'd255, 8'd0, 1'b1);
        send_sample(8'd0, 8'd255, 1'b1);
        send_sample(8'd128, 8'd127, 1'b1);
        send_sample(8'd1, 8'd1, 1'b1);

        // longest duration, skip near the end
        program_regs(8'd0, 8'd255, 16'hFFFF, 16'hFFFD, 16'd0, 1'b1);
        send_sample(8'd255, 8'd0, 1'b1);
        send_sample(8'd0, 8'd255, 1'b0);
        send_sample(8'd255, 8'd255, 1'b1);

        // zero duration
        program_regs(8'd0, 8'd255, 16'd0, 16'd0, 16'd0, 1'b0);
        send_sample(8'd200, 8'd100, 1'b1);
        send_sample(8'd10, 8'd20, 1'b1);

        // window past the duration
        program_regs(8'd10, 8'd200, 16'd4, 16'd2, 16'd3, 1'b0);
        send_sample(8'd50, 8'd60, 1'b0);
        send_sample(8'd70, 8'd80, 1'b1);

        // empty window
        program_regs(8'd0, 8'd255, 16'd5, 16'd5, 16'd0, 1'b0);
        send_sample(8'd1, 8'd2, 1'b1);
        send_sample(8'd3, 8'd4, 1'b1);

        // skip beyond the duration
        program_regs(8'd0, 8'd255, 16'd3, 16'hFFFF, 16'd1, 1'b0);
        send_sample(8'd9, 8'd9, 1'b1);

        // largest frame count
        program_regs(8'd0, 8'd255, 16'hFFFF, 16'd0, 16'hFFFF, 1'b1);
        send_sample(8'd255, 8'd0, 1'b1);
        send_sample(8'd0, 8'd255, 1'b1);

        base = words_sent;
        phase = 0;
        while (words_sent - base < RandomWords) begin
            op_a = rand_sample();
            op_b = rand_sample();
            kind = $urandom_range(0, 9);
            if (phase == HoldPhase) begin
                d = 16'd2;
                s = 16'd0;
                p = 16'd0;
            end else if (kind <= 5) begin
                d = 16'($urandom_range(1, 8));
                s = 16'($urandom_range(0, d - 1));
                p = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, d - s));
            end else if (kind == 6) begin
                d = 16'($urandom_range(2, 65535));
                s = d - 16'($urandom_range(1, 2));
                p = 16'd0;
            end else if (kind == 7) begin
                d = 16'($urandom_range(1, 8));
                case ($urandom_range(0, 2))
                    0: begin
                        s = 16'($urandom_range(0, d));
                        p = d - s + 16'($urandom_range(1, 3));
                    end
                    1: begin
                        s = d;
                        p = 16'd0;
                    end
                    default: begin
                        s = 16'($urandom_range(d + 1, 65535));
                        p = 16'($urandom);
                    end
                endcase
            end else if (kind == 8) begin
                d = 16'($urandom_range(1, 65535));
                s = 16'($urandom_range(0, d - 1));
                lim = (d - s < 3) ? int'(d - s) : 3;
                p = 16'($urandom_range(1, lim));
            end else begin
                d = 16'hFFFF;
                s = 16'($urandom_range(0, 3));
                p = 16'hFFFF - s;
            end
            program_regs(op_a, op_b, d, s, p, $urandom_range(0, 3) == 0);

            if (sb.window_ok) begin
                nfr = int'(sb.window_end) - int'(sb.skp);
                if (nfr > MaxFramesPerPhase) nfr = MaxFramesPerPhase;
            end else begin
                nfr = $urandom_range(1, 3);
            end
            nfr += $urandom_range(0, 2);

            if (phase == HoldPhase) hold_req = 1'b1;
            for (int f = 0; f < nfr; f++) begin
                if (phase == HoldPhase) flen = HoldFrameLen;
                else if ($urandom_range(0, 6) == 0) flen = $urandom_range(7, 24);
                else flen = $urandom_range(1, 6);
                send_frame(flen);
            end
            phase++;
        end

        wait_idle();
        sb.finish_check();
        $display("Ran %0d register settings and offered %0d words; %0d blended words checked.",
                 settings_run, words_sent, sb.checked);
        $display("Saw %0d frame ends and %0d completed transitions.",
                 sb.frame_ends, sb.transitions);
        if (sb.errors == 0) begin
            $display("PASS video_crossfade_blender_top");
        end else begin
            $display("FAIL video_crossfade_blender_top");
        end
        $finish;
    end

endmodule

FILE: video_crossfade_blender_top.f
src/vcb_pkg.sv
src/vcb_ramp.sv
src/vcb_front.sv
src/vcb_fifo.sv
src/vcb_back.sv
src/video_crossfade_blender_top.sv
src/vcb_checker.sv
tb/video_crossfade_blender_top_test.sv
